>>> rtl/pidl_pkg.sv
package pidl_pkg;

  // field widths fixed by the beat layout
  localparam int unsigned ActionW = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // beat widths, padded to whole bytes
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 40;

  // action codes
  localparam logic [ActionW-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ActionW-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ActionW-1:0] ACT_POP_BACK   = 3'd2;
  localparam logic [ActionW-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ActionW-1:0] ACT_INSERT     = 3'd4;
  localparam logic [ActionW-1:0] ACT_ERASE      = 3'd5;

  // status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;
  localparam logic [StatusW-1:0] ST_POS   = 2'd3;

  typedef logic signed [DataW-1:0] data_t;

  // what every cell does in one cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,  // cell at pos takes the value
    CELL_OPEN  = 2'd2,  // cell at pos takes the value, cells behind take left
    CELL_CLOSE = 2'd3   // cells from pos on take right, the last cell holds
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    data_t    value;
  } cell_cmd_t;

endpackage

>>> rtl/positional_insert_delete_list_top.sv
// channel | dir | tdata fields, lowest bit up
// in_     | in  | action[2:0] position[7:3] value[39:8]
// out_    | out | read_value[31:0] status[33:32] count[38:34] zero[39]
//
// one beat is taken per cycle while out_ does not stall: all cells shift in
// parallel when the beat is taken, and the output register is loaded with them
// the output register frees itself when taken, so a stall on out_ holds in_ only
// rst_n (synchronous, active low) empties the list and drops out_tvalid
// entry contents are not reset; only entries below the fill count are read
module positional_insert_delete_list_top
  import pidl_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [InTdataW-1:0]  in_tdata,   // action, position, value
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutTdataW-1:0] out_tdata   // read_value, status, count, pad
);

  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (FW > PosW) ? FW : PosW;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [FW-1:0] OneF   = FW'(1);

  logic [ActionW-1:0] action;
  logic [PosW-1:0]    position;
  data_t              value;
  logic               in_fire;

  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic [CW-1:0] fill_ext;
  logic [CW-1:0] pos_ext;
  logic          full;
  logic          empty;

  cell_cmd_t     cmd;
  cell_op_t      op;
  logic [FW-1:0] cell_pos;
  logic [FW-1:0] rd_pos;
  logic          rd_en;
  logic [StatusW-1:0] status;

  data_t cell_data [DEPTH];
  data_t cell_rd   [DEPTH];
  data_t rd_bus;
  data_t read_value;

  logic                 out_valid_r;
  logic [OutTdataW-1:0] out_tdata_r;

  // unpack input beat
  assign action   = in_tdata[2:0];
  assign position = in_tdata[7:3];
  assign value    = in_tdata[39:8];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign fill_ext = CW'(fill_r);
  assign pos_ext  = CW'(position);
  assign full     = (fill_ext >= DepthC);
  assign empty    = (fill_r == '0);

  // decode action into a cell command, status and new fill
  always_comb begin
    op       = CELL_HOLD;
    cell_pos = '0;
    rd_pos   = '0;
    rd_en    = 1'b0;
    status   = ST_OK;
    fill_nxt = fill_r;
    unique case (action)
      ACT_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op       = CELL_LOAD;
          cell_pos = fill_r;
          fill_nxt = fill_r + OneF;
        end
      end
      ACT_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op       = CELL_OPEN;
          fill_nxt = fill_r + OneF;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          rd_pos   = fill_r - OneF;
          fill_nxt = fill_r - OneF;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          op       = CELL_CLOSE;
          fill_nxt = fill_r - OneF;
        end
      end
      ACT_INSERT: begin
        if (pos_ext > fill_ext) begin
          status = ST_POS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          op       = CELL_OPEN;
          cell_pos = FW'(pos_ext);
          fill_nxt = fill_r + OneF;
        end
      end
      ACT_ERASE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_ext >= fill_ext) begin
          status = ST_POS;
        end else begin
          rd_en    = 1'b1;
          rd_pos   = FW'(pos_ext);
          op       = CELL_CLOSE;
          cell_pos = FW'(pos_ext);
          fill_nxt = fill_r - OneF;
        end
      end
      default: begin
        op = CELL_HOLD;
      end
    endcase
  end

  // cells move only on an accepted beat
  assign cmd.op    = in_fire ? op : CELL_HOLD;
  assign cmd.value = value;

  // row of cells, each fed by its neighbors, zero past either end
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    data_t left_d;
    data_t right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    pidl_cell #(
      .IDX  (g),
      .PW   (FW),
      .LAST (g == DEPTH - 1)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (cell_pos),
      .rd_pos     (rd_pos),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .rd_data    (cell_rd[g])
    );
  end

  // read bus: only the addressed cell drives nonzero
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  assign read_value = rd_en ? rd_bus : '0;

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_fire) begin
      fill_r <= fill_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= {1'b0, CountW'(fill_nxt), status, read_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> rtl/pidl_cell.sv
module pidl_cell
  import pidl_pkg::*;
#(
  parameter int unsigned IDX  = 0,
  parameter int unsigned PW   = 5,
  parameter bit          LAST = 1'b0
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [PW-1:0] pos,
  input  logic [PW-1:0] rd_pos,
  input  data_t         left_data,
  input  data_t         right_data,
  output data_t         data,
  output data_t         rd_data
);

  localparam logic [PW-1:0] MyIdx = PW'(IDX);

  data_t data_r;
  data_t data_nxt;
  logic  at_pos;
  logic  behind_pos;

  assign at_pos     = (pos == MyIdx);
  assign behind_pos = (MyIdx > pos);

  // next entry from own value, neighbor or input
  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_HOLD: begin
        data_nxt = data_r;
      end
      CELL_LOAD: begin
        if (at_pos) data_nxt = cmd.value;
      end
      CELL_OPEN: begin
        if (at_pos) data_nxt = cmd.value;
        else if (behind_pos) data_nxt = left_data;
      end
      CELL_CLOSE: begin
        if ((at_pos || behind_pos) && !LAST) data_nxt = right_data;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  // contribute to the read bus only when addressed
  assign rd_data = (rd_pos == MyIdx) ? data_r : '0;

endmodule

>>> tb/tb_positional_insert_delete_list_top.sv
module tb_positional_insert_delete_list_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pidl_pkg::*;

  localparam int unsigned Depth = 16;

  // action codes the block ignores
  localparam logic [ActionW-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ActionW-1:0] ACT_SPARE_7 = 3'd7;

  typedef struct packed {
    data_t              read_value;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
  } list_result_t;

  // shadow list plus the results it predicts, oldest first
  class list_scoreboard;
    data_t        held[$];
    list_result_t results_due[$];
    int unsigned  mismatches;

    function int unsigned fill();
      return held.size();
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    // apply one accepted action to the shadow list
    function void note_input(logic [ActionW-1:0] action, logic [PosW-1:0] pos, data_t value);
      list_result_t res;
      res.read_value = '0;
      res.status     = ST_OK;
      case (action)
        ACT_PUSH_BACK: begin
          if (held.size() >= Depth) res.status = ST_FULL;
          else held.push_back(value);
        end
        ACT_PUSH_FRONT: begin
          if (held.size() >= Depth) res.status = ST_FULL;
          else held.push_front(value);
        end
        ACT_POP_BACK: begin
          if (held.size() == 0) res.status = ST_EMPTY;
          else res.read_value = held.pop_back();
        end
        ACT_POP_FRONT: begin
          if (held.size() == 0) res.status = ST_EMPTY;
          else res.read_value = held.pop_front();
        end
        ACT_INSERT: begin
          // position is checked before fullness
          if (pos > held.size()) res.status = ST_POS;
          else if (held.size() >= Depth) res.status = ST_FULL;
          else held.insert(pos, value);
        end
        ACT_ERASE: begin
          if (held.size() == 0) res.status = ST_EMPTY;
          else if (pos >= held.size()) res.status = ST_POS;
          else begin
            res.read_value = held[pos];
            held.delete(pos);
          end
        end
        default: ;
      endcase
      res.count = CountW'(held.size());
      results_due.push_back(res);
    endfunction

    // compare one result beat with the oldest prediction
    function void check_result(logic [OutTdataW-1:0] beat);
      list_result_t got;
      list_result_t want;
      got.read_value = beat[DataW-1:0];
      got.status     = beat[DataW+StatusW-1:DataW];
      got.count      = beat[DataW+StatusW+CountW-1:DataW+StatusW];
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, beat);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                 got.read_value);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [InTdataW-1:0]  in_tdata   = '0;   // action, position, value
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutTdataW-1:0] out_tdata;         // read_value, status, count, pad

  bit             gaps_on = 1'b1;
  bit             growing = 1'b1;
  list_scoreboard board;

  positional_insert_delete_list_top #(
    .DEPTH(Depth)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // offer one beat after a random gap and wait until it is taken
  task automatic send_beat(input logic [ActionW-1:0] action, input logic [PosW-1:0] pos,
                           input data_t value);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {value, pos, action};
    do @(posedge clk); while (in_tready !== 1'b1);
    board.note_input(action, pos, value);
  endtask

  // take result beats with random stalls in between
  task automatic drain_results();
    int unsigned stall;
    forever begin
      stall = gaps_on ? $urandom_range(0, 19) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      board.check_result(out_tdata);
    end
  endtask

  function automatic data_t pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return data_t'(32'h8000_0000);
      1: return data_t'(32'h7fff_ffff);
      2: return data_t'(32'hffff_ffff);
      default: return '0;
    endcase
  endfunction

  // random action, biased toward filling or draining the list
  task automatic send_random();
    int unsigned          n;
    int unsigned          pick;
    logic [ActionW-1:0]   action;
    logic [PosW-1:0]      pos;
    n = board.fill();
    if (n >= Depth && $urandom_range(0, 3) != 0) growing = 1'b0;
    if (n == 0 && $urandom_range(0, 3) != 0) growing = 1'b1;
    if ($urandom_range(0, 49) == 0) growing = !growing;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      action = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
    end else if (pick < 70) begin
      case ($urandom_range(0, 2))
        0: action = growing ? ACT_PUSH_BACK : ACT_POP_BACK;
        1: action = growing ? ACT_PUSH_FRONT : ACT_POP_FRONT;
        default: action = growing ? ACT_INSERT : ACT_ERASE;
      endcase
    end else begin
      case ($urandom_range(0, 5))
        0: action = ACT_PUSH_BACK;
        1: action = ACT_PUSH_FRONT;
        2: action = ACT_POP_BACK;
        3: action = ACT_POP_FRONT;
        4: action = ACT_INSERT;
        default: action = ACT_ERASE;
      endcase
    end
    // mostly positions that hit the list, sometimes anything in range
    if ($urandom_range(0, 9) == 0) pos = PosW'($urandom_range(0, 16));
    else if (action == ACT_INSERT) pos = PosW'($urandom_range(0, n));
    else if (action == ACT_ERASE) pos = (n == 0) ? '0 : PosW'($urandom_range(0, n - 1));
    else pos = PosW'($urandom_range(0, 16));
    send_beat(action, pos, pick_value());
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none

    // empty list: removals refused, bad insert position
    send_beat(ACT_POP_BACK, 5'd0, '0);
    send_beat(ACT_POP_FRONT, 5'd0, '0);
    send_beat(ACT_ERASE, 5'd0, '0);
    send_beat(ACT_ERASE, 5'd16, '0);
    send_beat(ACT_INSERT, 5'd1, data_t'(32'h1111_1111));

    // build a short list with extreme values
    send_beat(ACT_INSERT, 5'd0, data_t'(32'h8000_0000));
    send_beat(ACT_PUSH_BACK, 5'd0, data_t'(32'h7fff_ffff));
    send_beat(ACT_PUSH_FRONT, 5'd16, data_t'(32'hffff_ffff));
    send_beat(ACT_PUSH_BACK, 5'd0, '0);
    send_beat(ACT_INSERT, 5'd2, data_t'(32'h5a5a_a5a5));
    send_beat(ACT_INSERT, 5'd5, data_t'(32'h1234_5678));

    // erase past the end, erase in the middle, ignored codes, pop both ends
    send_beat(ACT_ERASE, 5'd6, '0);
    send_beat(ACT_ERASE, 5'd16, '0);
    send_beat(ACT_ERASE, 5'd2, '0);
    send_beat(ACT_SPARE_6, 5'd16, data_t'(32'hdead_beef));
    send_beat(ACT_SPARE_7, 5'd0, data_t'(32'h0bad_f00d));
    send_beat(ACT_POP_FRONT, 5'd0, '0);
    send_beat(ACT_POP_BACK, 5'd0, '0);

    // fill up, then everything that needs room is refused, and the last entry is erased
    while (board.fill() < Depth)
      send_beat(ACT_INSERT, PosW'($urandom_range(0, board.fill())), $urandom);
    send_beat(ACT_PUSH_BACK, 5'd0, '0);
    send_beat(ACT_PUSH_FRONT, 5'd0, '0);
    send_beat(ACT_INSERT, 5'd16, '0);
    send_beat(ACT_INSERT, 5'd0, '0);
    send_beat(ACT_ERASE, 5'd15, '0);

    // random traffic
    repeat (1300) begin
      send_random();
    end
    in_tvalid <= 1'b0;
    gaps_on = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pidl_pkg.sv
rtl/pidl_cell.sv
rtl/positional_insert_delete_list_top.sv
tb/tb_positional_insert_delete_list_top.sv
